// ----- rtl/core/sfa_pkg.sv -----
package sfa_pkg;

   localparam int unsigned Q10_ONE = 1024;

   // register indexes on the csr port
   localparam logic [2:0] CSR_WEIGHT_AGREEMENT    = 3'd0;
   localparam logic [2:0] CSR_WEIGHT_FRESHNESS    = 3'd1;
   localparam logic [2:0] CSR_WEIGHT_TRANSPORT    = 3'd2;
   localparam logic [2:0] CSR_MIN_CONFIDENCE      = 3'd3;
   localparam logic [2:0] CSR_SOFT_RETRY_LIMIT    = 3'd4;
   localparam logic [2:0] CSR_HARD_MISMATCH_LIMIT = 3'd5;
   localparam logic [2:0] CSR_WINDOW_LENGTH       = 3'd6;

   // state codes as reported on the result word
   localparam logic [2:0] CODE_IDLE   = 3'd0;
   localparam logic [2:0] CODE_CAND   = 3'd1;
   localparam logic [2:0] CODE_CONF   = 3'd2;
   localparam logic [2:0] CODE_ACTIVE = 3'd3;
   localparam logic [2:0] CODE_SOFT   = 3'd4;
   localparam logic [2:0] CODE_HARD   = 3'd5;
   localparam logic [2:0] CODE_DEGR   = 3'd6;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CAND   = 7'b0000010,
      ST_CONF   = 7'b0000100,
      ST_ACTIVE = 7'b0001000,
      ST_SOFT   = 7'b0010000,
      ST_HARD   = 7'b0100000,
      ST_DEGR   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic        command;
      logic        rad_seen;
      logic        rad_old;
      logic        cam_seen;
      logic        cam_old;
      logic        watchdog_good;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  fsm_state;
      logic        act_enable;
      logic [10:0] fused_conf;
      logic [10:0] radar_confidence;
      logic [10:0] camera_confidence;
      logic [4:0]  mismatch_total;
      logic [15:0] retry_total;
      logic        radar_faulted;
      logic        camera_faulted;
      logic        sensors_agree;
   } rsp_type;

   typedef struct packed {
      logic [10:0] weight_agreement;
      logic [10:0] weight_freshness;
      logic [10:0] weight_transport;
      logic [10:0] conf_floor;
      logic [31:0] soft_retry_limit;
      logic [4:0]  hard_mismatch_limit;
      logic [4:0]  window_length;
   } cfg_type;

   // per-sensor Q10 confidence, clamped to one
   function automatic logic [10:0] confidence(input cfg_type cfg, input logic agree,
                                              input logic stale, input logic wd);
      logic [12:0] sum;
      sum = 13'd0;
      if (agree) sum = sum + 13'(cfg.weight_agreement);
      if (!stale) sum = sum + 13'(cfg.weight_freshness);
      if (wd && !stale) sum = sum + 13'(cfg.weight_transport);
      if (sum > 13'(Q10_ONE)) sum = 13'(Q10_ONE);
      return sum[10:0];
   endfunction

   function automatic logic [2:0] state_code(input state_type st);
      logic [2:0] code;
      case (st)
         ST_IDLE:   code = CODE_IDLE;
         ST_CAND:   code = CODE_CAND;
         ST_CONF:   code = CODE_CONF;
         ST_ACTIVE: code = CODE_ACTIVE;
         ST_SOFT:   code = CODE_SOFT;
         ST_HARD:   code = CODE_HARD;
         ST_DEGR:   code = CODE_DEGR;
         default:   code = CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ----- rtl/core/sensor_fusion_activation_fsm.sv -----
// A request word passes the input register, then the result register, on its way to rsp_valid.
// Throughput: one word per cycle unless rsp_ready stalls; the whole update, window write
// and state step run in a single pass between the two registers.
// Reset (synchronous): state idle, entry time zero, retry count and mismatch
// window cleared, registers back to their defaults, both channels empty.
module sensor_fusion_activation_fsm #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sfa_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import sfa_pkg::*;

   localparam int SUM_W = $clog2(WINDOW_DEPTH + 1);

   cfg_type          cfg;
   logic             in_valid_ff;
   req_type          in_ff;
   logic             out_valid_ff;
   rsp_type          out_ff;
   rsp_type          out_in;
   state_type        state_ff;
   state_type        state_in;
   logic [31:0]      entered_ff;
   logic [31:0]      entered_in;
   logic [15:0]      retry_ff;
   logic [15:0]      retry_in;
   logic             advance;
   logic             agree;
   logic             ok;
   logic [10:0]      rc;
   logic [10:0]      cc;
   logic [11:0]      conf_sum;
   logic [SUM_W-1:0] win_sum;
   logic             timeout;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   sfa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sfa_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .push          (advance && !in_ff.command),
      .clear         (advance && in_ff.command),
      .mismatch_bit  (!agree),
      .window_length (cfg.window_length),
      .sum           (win_sum)
   );

   always_comb begin
      agree    = (in_ff.rad_seen == in_ff.cam_seen);
      rc       = confidence(cfg, agree, in_ff.rad_old, in_ff.watchdog_good);
      cc       = confidence(cfg, agree, in_ff.cam_old, in_ff.watchdog_good);
      conf_sum = 12'(rc) + 12'(cc);
      ok       = conf_sum >= {cfg.conf_floor, 1'b0};
      timeout  = (in_ff.time_ms - entered_ff) > cfg.soft_retry_limit;
   end

   always_comb begin
      state_in = state_ff;
      retry_in = retry_ff;
      if (in_ff.command) begin
         state_in = ST_IDLE;
         retry_in = 16'd0;
      end else if (in_ff.rad_old && in_ff.cam_old) begin
         state_in = ST_DEGR;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (in_ff.rad_seen && !in_ff.rad_old) state_in = ST_CAND;
            end
            ST_CAND: begin
               state_in = in_ff.rad_old ? ST_IDLE : ST_CONF;
            end
            ST_CONF: begin
               if (in_ff.cam_old) state_in = ST_SOFT;
               else if (agree && ok) state_in = ST_ACTIVE;
               else if (!in_ff.rad_seen && !in_ff.cam_seen) state_in = ST_IDLE;
               else state_in = ST_SOFT;
            end
            ST_ACTIVE: begin
               if (!in_ff.rad_seen && !in_ff.cam_seen) state_in = ST_IDLE;
               else if (!agree || !ok) state_in = ST_SOFT;
            end
            ST_SOFT: begin
               if (retry_ff != 16'hFFFF) retry_in = retry_ff + 16'd1;
               if (32'(win_sum) >= 32'(cfg.hard_mismatch_limit)) state_in = ST_HARD;
               else if (timeout) state_in = ST_HARD;
               else if (agree && ok) state_in = ST_CONF;
            end
            ST_HARD: begin
               state_in = ST_HARD;
            end
            ST_DEGR: begin
               state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
      // stamp entry time on a state change only
      entered_in = (state_in != state_ff) ? in_ff.time_ms : entered_ff;
   end

   always_comb begin
      out_in.fsm_state   = state_code(state_in);
      out_in.act_enable  = (state_in == ST_ACTIVE);
      out_in.retry_total = retry_in;
      if (in_ff.command) begin
         out_in.fused_conf        = 11'd0;
         out_in.radar_confidence  = 11'd0;
         out_in.camera_confidence = 11'd0;
         out_in.mismatch_total    = 5'd0;
         out_in.radar_faulted     = 1'b0;
         out_in.camera_faulted    = 1'b0;
         out_in.sensors_agree     = 1'b0;
      end else begin
         out_in.fused_conf        = conf_sum[11:1];
         out_in.radar_confidence  = rc;
         out_in.camera_confidence = cc;
         out_in.mismatch_total    = 5'(win_sum);
         out_in.radar_faulted     = in_ff.rad_old || !in_ff.watchdog_good;
         out_in.camera_faulted    = in_ff.cam_old || !in_ff.watchdog_good;
         out_in.sensors_agree     = agree;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         entered_ff   <= 32'd0;
         retry_ff     <= 16'd0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
            entered_ff   <= entered_in;
            retry_ff     <= retry_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_ff <= req_data;
      if (advance) out_ff <= out_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.act_enable == (rsp_data.fsm_state == CODE_ACTIVE)))
      else $error("activation flag disagrees with state code");

   assert property (@(posedge clock) disable iff (reset)
      (advance && in_ff.command) |=> (rsp_valid && rsp_data.fsm_state == CODE_IDLE
                                      && rsp_data.mismatch_total == 5'd0
                                      && rsp_data.retry_total == 16'd0))
      else $error("reset command result not cleared");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_ff)))
      else $error("held input word lost or changed");

   assert property (@(posedge clock) disable iff (reset)
      (retry_ff == 16'hFFFF && !(advance && in_ff.command)) |=> (retry_ff == 16'hFFFF))
      else $error("retry count wrapped");

endmodule

// ----- rtl/core/sfa_csr.sv -----
module sfa_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output sfa_pkg::cfg_type cfg
);
   import sfa_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WEIGHT_AGREEMENT:    cfg_in.weight_agreement    = csr_wdata[10:0];
            CSR_WEIGHT_FRESHNESS:    cfg_in.weight_freshness    = csr_wdata[10:0];
            CSR_WEIGHT_TRANSPORT:    cfg_in.weight_transport    = csr_wdata[10:0];
            CSR_MIN_CONFIDENCE:      cfg_in.conf_floor          = csr_wdata[10:0];
            CSR_SOFT_RETRY_LIMIT:    cfg_in.soft_retry_limit    = csr_wdata;
            CSR_HARD_MISMATCH_LIMIT: cfg_in.hard_mismatch_limit = csr_wdata[4:0];
            CSR_WINDOW_LENGTH:       cfg_in.window_length       = csr_wdata[4:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight_agreement    <= 11'd512;
         cfg_ff.weight_freshness    <= 11'd307;
         cfg_ff.weight_transport    <= 11'd205;
         cfg_ff.conf_floor          <= 11'd614;
         cfg_ff.soft_retry_limit    <= 32'd3000;
         cfg_ff.hard_mismatch_limit <= 5'd4;
         cfg_ff.window_length       <= 5'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/sfa_window.sv -----
module sfa_window #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  logic                                  clear,
   input  logic                                  mismatch_bit,
   input  logic [4:0]                            window_length,
   output logic [$clog2(WINDOW_DEPTH + 1) - 1:0] sum
);
   localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

   logic [WINDOW_DEPTH-1:0] win_ff;
   logic [WINDOW_DEPTH-1:0] win_in;
   logic [WINDOW_DEPTH-1:0] win_wr;
   logic [WINDOW_DEPTH-1:0] mask;
   logic [SLOT_W-1:0]       slot_ff;
   logic [SLOT_W-1:0]       slot_in;
   logic [SLOT_W-1:0]       slot_eff;
   logic [LEN_W-1:0]        len_eff;
   logic [LEN_W-1:0]        slot_next;

   // clamp the programmed length into 1..depth
   always_comb begin
      if (window_length == 5'd0) begin
         len_eff = LEN_W'(1);
      end else if (32'(window_length) > 32'(WINDOW_DEPTH)) begin
         len_eff = LEN_W'(WINDOW_DEPTH);
      end else begin
         len_eff = LEN_W'(window_length);
      end
   end

   always_comb begin
      // a slot left past a shrunk window restarts at entry zero
      slot_eff  = (LEN_W'(slot_ff) < len_eff) ? slot_ff : '0;
      slot_next = LEN_W'(slot_eff) + LEN_W'(1);
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         win_wr[i] = (SLOT_W'(i) == slot_eff) ? mismatch_bit : win_ff[i];
         mask[i]   = (32'(i) < 32'(len_eff));
      end
      sum = LEN_W'($countones(win_wr & mask));
   end

   always_comb begin
      win_in  = win_ff;
      slot_in = slot_ff;
      if (clear) begin
         win_in  = '0;
         slot_in = '0;
      end else if (push) begin
         win_in  = win_wr;
         slot_in = (slot_next >= len_eff) ? '0 : SLOT_W'(slot_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         slot_ff <= '0;
      end else begin
         win_ff  <= win_in;
         slot_ff <= slot_in;
      end
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import sfa_pkg::*;

   localparam int          WINDOW_DEPTH   = 16;
   localparam int          PHASES         = 10;
   localparam int          PHASE_ITEMS    = 170;
   localparam int          PRESSURE_PHASE = 5;
   localparam int          HOLD_CYCLES    = 300;
   localparam logic [2:0]  CSR_UNMAPPED   = 3'd7;

   class activation_scoreboard;
      cfg_type     cfg;
      logic [2:0]  mode;
      logic [31:0] entered_ms;
      logic        mismatch_bits [WINDOW_DEPTH];
      int unsigned slot;
      logic [15:0] retries;
      rsp_type     predicted_status [$];
      int unsigned error_count;

      function new();
         cfg.weight_agreement    = 11'd512;
         cfg.weight_freshness    = 11'd307;
         cfg.weight_transport    = 11'd205;
         cfg.conf_floor          = 11'd614;
         cfg.soft_retry_limit    = 32'd3000;
         cfg.hard_mismatch_limit = 5'd4;
         cfg.window_length       = 5'd8;
         mode = CODE_IDLE;
         entered_ms = '0;
         foreach (mismatch_bits[i]) mismatch_bits[i] = 1'b0;
         slot = 0;
         retries = '0;
         error_count = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [31:0] data);
         case (index)
            CSR_WEIGHT_AGREEMENT:    cfg.weight_agreement    = data[10:0];
            CSR_WEIGHT_FRESHNESS:    cfg.weight_freshness    = data[10:0];
            CSR_WEIGHT_TRANSPORT:    cfg.weight_transport    = data[10:0];
            CSR_MIN_CONFIDENCE:      cfg.conf_floor          = data[10:0];
            CSR_SOFT_RETRY_LIMIT:    cfg.soft_retry_limit    = data;
            CSR_HARD_MISMATCH_LIMIT: cfg.hard_mismatch_limit = data[4:0];
            CSR_WINDOW_LENGTH:       cfg.window_length       = data[4:0];
            default: ;
         endcase
      endfunction

      function void move_to(logic [2:0] next, logic [31:0] now);
         if (mode != next) begin
            mode = next;
            entered_ms = now;
         end
      endfunction

      function int unsigned channel_conf(logic agree, logic stale, logic wd);
         int unsigned s;
         s = 0;
         if (agree) s += cfg.weight_agreement;
         if (!stale) s += cfg.weight_freshness;
         if (wd && !stale) s += cfg.weight_transport;
         return (s > Q10_ONE) ? Q10_ONE : s;
      endfunction

      function void note_update(req_type r);
         rsp_type     want;
         int unsigned rc, cc, n, s, sum;
         logic        agree, ok;
         logic [31:0] dwell;
         want = '0;
         if (r.command) begin
            move_to(CODE_IDLE, r.time_ms);
            retries = '0;
            foreach (mismatch_bits[i]) mismatch_bits[i] = 1'b0;
            slot = 0;
         end else begin
            agree = (r.rad_seen == r.cam_seen);
            rc = channel_conf(agree, r.rad_old, r.watchdog_good);
            cc = channel_conf(agree, r.cam_old, r.watchdog_good);
            ok = (rc + cc) >= 2 * int'(cfg.conf_floor);
            // effective window length: zero acts as one, saturate at the depth
            n = cfg.window_length;
            if (n == 0) n = 1;
            if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
            s = (slot < n) ? slot : 0;
            mismatch_bits[s] = !agree;
            slot = (s + 1 >= n) ? 0 : s + 1;
            sum = 0;
            for (int i = 0; i < n; i++) sum += mismatch_bits[i];

            if (r.rad_old && r.cam_old) begin
               move_to(CODE_DEGR, r.time_ms);
            end else begin
               case (mode)
                  CODE_IDLE: begin
                     if (r.rad_seen && !r.rad_old) move_to(CODE_CAND, r.time_ms);
                  end
                  CODE_CAND: begin
                     move_to(r.rad_old ? CODE_IDLE : CODE_CONF, r.time_ms);
                  end
                  CODE_CONF: begin
                     if (r.cam_old) move_to(CODE_SOFT, r.time_ms);
                     else if (agree && ok) move_to(CODE_ACTIVE, r.time_ms);
                     else if (!r.rad_seen && !r.cam_seen)
                        move_to(CODE_IDLE, r.time_ms);
                     else move_to(CODE_SOFT, r.time_ms);
                  end
                  CODE_ACTIVE: begin
                     if (!r.rad_seen && !r.cam_seen) move_to(CODE_IDLE, r.time_ms);
                     else if (!agree || !ok) move_to(CODE_SOFT, r.time_ms);
                  end
                  CODE_SOFT: begin
                     if (retries != 16'hFFFF) retries = retries + 16'd1;
                     dwell = r.time_ms - entered_ms;
                     if (sum >= cfg.hard_mismatch_limit) move_to(CODE_HARD, r.time_ms);
                     else if (dwell > cfg.soft_retry_limit) move_to(CODE_HARD, r.time_ms);
                     else if (agree && ok) move_to(CODE_CONF, r.time_ms);
                  end
                  CODE_HARD: ;
                  default: move_to(CODE_IDLE, r.time_ms);
               endcase
            end
            want.fused_conf        = 11'((rc + cc) >> 1);
            want.radar_confidence  = 11'(rc);
            want.camera_confidence = 11'(cc);
            want.mismatch_total    = 5'(sum);
            want.retry_total       = retries;
            want.radar_faulted     = r.rad_old || !r.watchdog_good;
            want.camera_faulted    = r.cam_old || !r.watchdog_good;
            want.sensors_agree     = agree;
         end
         want.fsm_state  = mode;
         want.act_enable = (mode == CODE_ACTIVE);
         predicted_status.push_back(want);
      endfunction

      function void check_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
         end
      endfunction

      function void check_status(rsp_type got);
         rsp_type want;
         if (predicted_status.size() == 0) begin
            $error("status word with no update pending");
            error_count++;
            return;
         end
         want = predicted_status.pop_front();
         check_field("fsm_state", want.fsm_state, got.fsm_state);
         check_field("act_enable", want.act_enable, got.act_enable);
         check_field("fused_conf", want.fused_conf, got.fused_conf);
         check_field("radar_confidence", want.radar_confidence, got.radar_confidence);
         check_field("camera_confidence", want.camera_confidence, got.camera_confidence);
         check_field("mismatch_total", want.mismatch_total, got.mismatch_total);
         check_field("retry_total", want.retry_total, got.retry_total);
         check_field("radar_faulted", want.radar_faulted, got.radar_faulted);
         check_field("camera_faulted", want.camera_faulted, got.camera_faulted);
         check_field("sensors_agree", want.sensors_agree, got.sensors_agree);
      endfunction

      function int unsigned pending();
         return predicted_status.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_WEIGHT_AGREEMENT;
   logic [31:0] csr_wdata = '0;

   bit steady = 1'b0;
   bit hold_off_req = 1'b0;
   bit hold_active = 1'b0;

   activation_scoreboard sb = new();

   sensor_fusion_activation_fsm dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("[sensor_fusion_activation_fsm] ERROR");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type sensor_word(logic cmd, logic rp, logic rs, logic cp,
                                           logic cs, logic wd, logic [31:0] t);
      req_type w;
      w.command       = cmd;
      w.rad_seen      = rp;
      w.rad_old       = rs;
      w.cam_seen      = cp;
      w.cam_old       = cs;
      w.watchdog_good = wd;
      w.time_ms       = t;
      return w;
   endfunction

   // mostly healthy, agreeing updates so the machine climbs to active
   function automatic req_type random_sensor_word(logic [31:0] t);
      req_type     w;
      int unsigned k;
      k = $urandom_range(0, 99);
      w = sensor_word(1'b0, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      1'($urandom), t);
      if (k < 2) begin
         w.command = 1'b1;
      end else if (k < 75) begin
         w.rad_seen      = ($urandom_range(0, 9) != 0);
         w.cam_seen      = w.rad_seen ^ ($urandom_range(0, 7) == 0);
         w.rad_old       = ($urandom_range(0, 15) == 0);
         w.cam_old       = ($urandom_range(0, 15) == 0);
         w.watchdog_good = ($urandom_range(0, 11) != 0);
      end
      return w;
   endfunction

   function automatic logic [31:0] pad(logic [31:0] value, int unsigned width, bit noisy);
      logic [31:0] junk;
      junk = (noisy && width < 32) ? ($urandom << width) : 32'd0;
      return value | junk;
   endfunction

   task automatic send_request(input req_type w, input int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_config(input cfg_type c, input bit noisy);
      write_reg(CSR_WEIGHT_AGREEMENT, pad(32'(c.weight_agreement), 11, noisy));
      write_reg(CSR_WEIGHT_FRESHNESS, pad(32'(c.weight_freshness), 11, noisy));
      write_reg(CSR_WEIGHT_TRANSPORT, pad(32'(c.weight_transport), 11, noisy));
      write_reg(CSR_MIN_CONFIDENCE, pad(32'(c.conf_floor), 11, noisy));
      write_reg(CSR_SOFT_RETRY_LIMIT, c.soft_retry_limit);
      write_reg(CSR_HARD_MISMATCH_LIMIT, pad(32'(c.hard_mismatch_limit), 5, noisy));
      write_reg(CSR_WINDOW_LENGTH, pad(32'(c.window_length), 5, noisy));
      if (noisy) write_reg(CSR_UNMAPPED, $urandom);
      csr_valid <= 1'b0;
   endtask

   // wait until every status word is back, then let the pipeline drain
   task automatic settle();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic plan_settings(input int p, output cfg_type c, output bit noisy);
      noisy = 1'b0;
      c.weight_agreement    = 11'd512;
      c.weight_freshness    = 11'd307;
      c.weight_transport    = 11'd205;
      c.conf_floor          = 11'd614;
      c.soft_retry_limit    = 32'd3000;
      c.hard_mismatch_limit = 5'd4;
      c.window_length       = 5'd8;
      case (p)
         0: c = '0;
         1: begin
            c.weight_agreement    = 11'd1024;
            c.weight_freshness    = 11'd1024;
            c.weight_transport    = 11'd1024;
            c.conf_floor          = 11'd1024;
            c.soft_retry_limit    = 32'hFFFF_FFFF;
            c.hard_mismatch_limit = 5'd16;
            c.window_length       = 5'd16;
         end
         2: begin
            noisy = 1'b1;
            c.weight_agreement    = 11'($urandom_range(0, 2047));
            c.weight_freshness    = 11'($urandom_range(0, 2047));
            c.weight_transport    = 11'($urandom_range(0, 2047));
            c.conf_floor          = 11'($urandom_range(0, 2047));
            c.soft_retry_limit    = $urandom;
            c.hard_mismatch_limit = 5'd31;
            c.window_length       = 5'd31;
         end
         3: begin
            // shrink the window under a slot that may sit beyond it
            c.soft_retry_limit    = 32'd20;
            c.hard_mismatch_limit = 5'd1;
            c.window_length       = 5'd1;
         end
         4: ;
         PRESSURE_PHASE: c.window_length = 5'd3;
         default: begin
            c.weight_agreement    = 11'($urandom_range(0, 1024));
            c.weight_freshness    = 11'($urandom_range(0, 1024));
            c.weight_transport    = 11'($urandom_range(0, 1024));
            c.conf_floor          = 11'($urandom_range(0, 1024));
            c.soft_retry_limit    = ($urandom_range(0, 3) == 0) ? 32'd3000
                                                                : $urandom_range(0, 400);
            c.hard_mismatch_limit = 5'($urandom_range(0, 16));
            c.window_length       = 5'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                                 : $urandom_range(1, 16));
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_register(csr_index, csr_wdata);
         if (req_valid && req_ready) sb.note_update(req_data);
         if (rsp_valid && rsp_ready) sb.check_status(rsp_data);
      end
   end

   // result side: random stalls, plus one long hold-off to back up the block
   initial begin : sink
      int unsigned len;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_active  = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active  = 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            len = idle_len();
            if (len == 0) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat (len) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      req_type     directed [$];
      cfg_type     c;
      bit          noisy;
      logic [31:0] now_ms;
      int unsigned span;
      int unsigned gap;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the state machine under the reset register values
      directed.push_back(sensor_word(0, 0, 0, 0, 0, 1, 32'd100));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'd110));
      directed.push_back(sensor_word(0, 1, 1, 1, 0, 1, 32'd120));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'd130));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'd140));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'd150));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'd160));
      directed.push_back(sensor_word(0, 0, 0, 0, 0, 1, 32'd170));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'd180));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'd190));
      directed.push_back(sensor_word(0, 1, 0, 1, 1, 1, 32'd200));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'd300));
      directed.push_back(sensor_word(0, 1, 0, 0, 0, 1, 32'd310));
      directed.push_back(sensor_word(0, 1, 0, 0, 0, 0, 32'd5000));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 0, 32'd5010));
      directed.push_back(sensor_word(0, 1, 1, 0, 1, 1, 32'd5020));
      directed.push_back(sensor_word(0, 0, 0, 0, 0, 1, 32'd5030));
      directed.push_back(sensor_word(1, 1, 1, 1, 1, 1, 32'd5040));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'hFFFF_FFFF));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'd0));
      directed.push_back(sensor_word(0, 1, 0, 1, 0, 1, 32'd1));
      directed.push_back(sensor_word(0, 1, 0, 0, 0, 1, 32'd2));
      directed.push_back(sensor_word(0, 0, 0, 1, 0, 1, 32'd3));
      directed.push_back(sensor_word(0, 0, 0, 1, 0, 1, 32'd4));
      directed.push_back(sensor_word(0, 0, 0, 1, 0, 1, 32'd5));
      foreach (directed[i]) send_request(directed[i], idle_len());

      now_ms = 32'd1000;
      for (int p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         settle();
         plan_settings(p, c, noisy);
         program_config(c, noisy);
         if (p == 4) now_ms = 32'hFFFF_F000;
         steady = (p == 3) || (p == 7);
         if (p == PRESSURE_PHASE) hold_off_req = 1'b1;
         span = (c.soft_retry_limit < 32'd3000) ? c.soft_retry_limit + 2 : 3000;
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 32) == 0) now_ms = $urandom;
            else now_ms = now_ms + $urandom_range(0, span);
            gap = (steady || hold_active) ? 0 : idle_len();
            send_request(random_sensor_word(now_ms), gap);
         end
         steady = 1'b0;
      end

      req_valid <= 1'b0;
      settle();
      repeat (8) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("[sensor_fusion_activation_fsm] OK");
      end else begin
         $display("[sensor_fusion_activation_fsm] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/sfa_pkg.sv
rtl/core/sfa_csr.sv
rtl/core/sfa_window.sv
rtl/core/sensor_fusion_activation_fsm.sv
verif/tb.sv
